### hw/rtl/sliding_window_median_top_macros.svh
// Assertion macros for the sliding window median block.
// Used by sliding_window_median_top; expects clk_i and rst_ni in scope.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define SWM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("swm invariant violated");

// antecedent at one edge implies consequent at the next
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swm sequence violated");

`endif

### hw/rtl/swm_pkg.sv
// Shared types and constants for the sliding window median block.
// No dependencies.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int CFG_WIDTH    = 7;
  localparam int WINDOW_RESET = 3;

  typedef struct packed {
    logic load;
    logic remove;
  } chain_ctrl_t;

endpackage

### hw/rtl/swm_cell.sv
// One cell of the sorted sample chain: value plus age, evict and insert step.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_cell #(
  parameter int IDX = 0,
  parameter int SW  = 32,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  logic                   clk_i,
  input  swm_pkg::chain_ctrl_t   ctrl_i,
  input  logic [CW-1:0]          n_old_i,
  input  logic [CW-1:0]          n_rem_i,
  input  logic [IW-1:0]          age_last_i,
  input  logic signed [SW-1:0]   sample_i,
  input  logic signed [SW-1:0]   right_val_i,
  input  logic [IW-1:0]          right_age_i,
  input  logic signed [SW-1:0]   left_bval_i,
  input  logic [IW-1:0]          left_bage_i,
  input  logic                   left_le_i,
  input  logic                   left_rb_i,
  output logic signed [SW-1:0]   val_o,
  output logic [IW-1:0]          age_o,
  output logic signed [SW-1:0]   bval_o,
  output logic [IW-1:0]          bage_o,
  output logic                   le_o,
  output logic                   rb_o
);
  import swm_pkg::*;

  logic signed [SW-1:0] val_q, val_d;
  logic [IW-1:0]        age_q, age_d;
  logic                 occ_old, rm;

  // evict: oldest occupied sample leaves, cells to its right move left
  assign occ_old = CW'(IDX) < n_old_i;
  assign rm      = ctrl_i.remove && occ_old && (age_q == age_last_i);
  assign rb_o    = left_rb_i | rm;
  assign bval_o  = rb_o ? right_val_i : val_q;
  assign bage_o  = rb_o ? right_age_i : age_q;
  assign le_o    = (CW'(IDX) < n_rem_i) && (bval_o <= sample_i);

  // insert: new sample goes after every value not above it
  always_comb begin
    if (le_o) begin
      val_d = bval_o;
      age_d = bage_o + 1'b1;
    end else if (left_le_i) begin
      val_d = sample_i;
      age_d = '0;
    end else begin
      val_d = left_bval_i;
      age_d = left_bage_i + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o = val_q;
  assign age_o = age_q;

endmodule

### hw/rtl/swm_chain.sv
// Row of sorted cells with taps at the two middle positions.
// Depends on swm_pkg and swm_cell.
`timescale 1ns / 1ps

module swm_chain #(
  parameter int MAX_WINDOW = 64,
  parameter int SW         = 32,
  parameter int IW         = 6,
  parameter int CW         = 7
) (
  input  logic                   clk_i,
  input  swm_pkg::chain_ctrl_t   ctrl_i,
  input  logic [CW-1:0]          n_old_i,
  input  logic [CW-1:0]          n_rem_i,
  input  logic [IW-1:0]          age_last_i,
  input  logic signed [SW-1:0]   sample_i,
  input  logic [IW-1:0]          lo_idx_i,
  input  logic [IW-1:0]          hi_idx_i,
  output logic signed [SW-1:0]   lo_val_o,
  output logic signed [SW-1:0]   hi_val_o
);
  import swm_pkg::*;

  logic signed [SW-1:0] val  [MAX_WINDOW];
  logic [IW-1:0]        age  [MAX_WINDOW];
  logic signed [SW-1:0] bval [MAX_WINDOW];
  logic [IW-1:0]        bage [MAX_WINDOW];
  logic                 le   [MAX_WINDOW];
  logic                 rb   [MAX_WINDOW];

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    logic signed [SW-1:0] l_bval, r_val;
    logic [IW-1:0]        l_bage, r_age;
    logic                 l_le, l_rb;

    if (g == 0) begin : g_head
      assign l_bval = '0;
      assign l_bage = '0;
      assign l_le   = 1'b1;
      assign l_rb   = 1'b0;
    end else begin : g_link
      assign l_bval = bval[g-1];
      assign l_bage = bage[g-1];
      assign l_le   = le[g-1];
      assign l_rb   = rb[g-1];
    end

    if (g == MAX_WINDOW - 1) begin : g_tail
      assign r_val = '0;
      assign r_age = '0;
    end else begin : g_next
      assign r_val = val[g+1];
      assign r_age = age[g+1];
    end

    swm_cell #(
      .IDX (g),
      .SW  (SW),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_i),
      .n_old_i     (n_old_i),
      .n_rem_i     (n_rem_i),
      .age_last_i  (age_last_i),
      .sample_i    (sample_i),
      .right_val_i (r_val),
      .right_age_i (r_age),
      .left_bval_i (l_bval),
      .left_bage_i (l_bage),
      .left_le_i   (l_le),
      .left_rb_i   (l_rb),
      .val_o       (val[g]),
      .age_o       (age[g]),
      .bval_o      (bval[g]),
      .bage_o      (bage[g]),
      .le_o        (le[g]),
      .rb_o        (rb[g])
    );
  end

  assign lo_val_o = val[lo_idx_i];
  assign hi_val_o = val[hi_idx_i];

endmodule

### hw/rtl/sliding_window_median_top.sv
// Throughput: one sample per cycle while in_stall_o is low; eviction and sorted insert ripple along the cell chain.
// An accepted sample is written into the cell chain; the two middle values of its window
//   then go to the middle-value tap register, and their sum to the sum register.
// Reset: window size 3, window empty, no result pending; cell contents are not reset.
// Depends on swm_pkg, swm_chain, swm_cell and the assertion macro header.
`timescale 1ns / 1ps

`include "sliding_window_median_top_macros.svh"

module sliding_window_median_top #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [swm_pkg::CFG_WIDTH-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]      sample_i,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [SAMPLE_BITS:0]        median_doubled_o
);
  import swm_pkg::*;

  localparam int SW   = SAMPLE_BITS;
  localparam int IW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int CMPW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;
  localparam int WR   = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

  logic [CW-1:0]   w_q, w_d, w_m1, fill_q, fill_d, n_eff, n_rem;
  logic [CMPW-1:0] cfg_ext;
  logic            remove, result;
  logic            pend_q, pend_d, sel_v_q, sel_v_d, out_v_q, out_v_d;
  logic            load, adv_out, sel_take;
  chain_ctrl_t     ctrl;

  logic signed [SW-1:0] lo_val, hi_val, lo_q, hi_q;
  logic signed [SW:0]   out_q;

  // window size clamp on write
  assign cfg_ext = CMPW'(cfg_data_i);
  always_comb begin
    if (cfg_ext == '0) begin
      w_d = CW'(1);
    end else if (cfg_ext > CMPW'(MAX_WINDOW)) begin
      w_d = CW'(MAX_WINDOW);
    end else begin
      w_d = CW'(cfg_ext);
    end
  end

  assign w_m1     = w_q - 1'b1;
  assign adv_out  = !out_v_q || !out_stall_i;
  assign sel_take = !sel_v_q || adv_out;
  assign in_stall_o = pend_q && !sel_take;
  assign load     = in_valid_i && !in_stall_o;

  assign n_eff  = restart_i ? '0 : fill_q;
  assign remove = (n_eff == w_q);
  assign n_rem  = n_eff - CW'(remove);
  assign result = ((n_rem + 1'b1) == w_q);

  assign ctrl.load   = load;
  assign ctrl.remove = remove;

  always_comb begin
    fill_d = fill_q;
    if (cfg_we_i) begin
      fill_d = '0;
    end else if (load) begin
      fill_d = n_rem + 1'b1;
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (pend_q && sel_take) begin
      pend_d = 1'b0;
    end
    if (load) begin
      pend_d = result;
    end
  end

  always_comb begin
    sel_v_d = sel_v_q;
    if (sel_v_q && adv_out) begin
      sel_v_d = 1'b0;
    end
    if (pend_q && sel_take) begin
      sel_v_d = 1'b1;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
    if (sel_v_q && adv_out) begin
      out_v_d = 1'b1;
    end
  end

  swm_chain #(
    .MAX_WINDOW (MAX_WINDOW),
    .SW         (SW),
    .IW         (IW),
    .CW         (CW)
  ) u_chain (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .n_old_i    (n_eff),
    .n_rem_i    (n_rem),
    .age_last_i (w_m1[IW-1:0]),
    .sample_i   (sample_i),
    .lo_idx_i   (IW'(w_m1 >> 1)),
    .hi_idx_i   (IW'(w_q >> 1)),
    .lo_val_o   (lo_val),
    .hi_val_o   (hi_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= CW'(WR);
      fill_q  <= '0;
      pend_q  <= 1'b0;
      sel_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        w_q <= w_d;
      end
      fill_q  <= fill_d;
      pend_q  <= pend_d;
      sel_v_q <= sel_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q && sel_take) begin
      lo_q <= lo_val;
      hi_q <= hi_val;
    end
    if (sel_v_q && adv_out) begin
      out_q <= {lo_q[SW-1], lo_q} + {hi_q[SW-1], hi_q};
    end
  end

  assign out_valid_o      = out_v_q;
  assign median_doubled_o = out_q;

  `SWM_ASSERT_ALWAYS(a_fill_in_window, fill_q <= w_q)
  `SWM_ASSERT_ALWAYS(a_window_range, (w_q != '0) && (w_q <= CW'(MAX_WINDOW)))
  `SWM_ASSERT_NEXT(a_tap_holds, sel_v_q && !adv_out, sel_v_q)
  `SWM_ASSERT_NEXT(a_pend_holds, pend_q && !sel_take, pend_q)

endmodule

### tb/sliding_window_median_top_tb.sv
// Self-checking testbench for sliding_window_median_top: streams sample transactions under
// random window sizes, predicts each doubled median and checks it on the result channel.
// Depends on swm_pkg and the sliding_window_median_top RTL.
`timescale 1ns / 1ps

module sliding_window_median_top_tb;
  import swm_pkg::*;

  localparam int MAX_WIN      = 64;
  localparam int SBITS        = 32;
  localparam int RANDOM_ITEMS = 750;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic signed [SBITS-1:0] sample_t;
  typedef logic signed [SBITS:0]   median_t;

  typedef struct packed {
    logic signed [SBITS-1:0] sample;
    logic                    restart;
  } sample_txn_t;

  localparam sample_t S_MIN = {1'b1, {(SBITS-1){1'b0}}};
  localparam sample_t S_MAX = {1'b0, {(SBITS-1){1'b1}}};

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  sample_t              sample_i    = '0;
  logic                 restart_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  median_t              median_doubled_o;

  sliding_window_median_top #(
    .MAX_WINDOW (MAX_WIN),
    .SAMPLE_BITS(SBITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .median_doubled_o(median_doubled_o)
  );

  // window state mirrored from the accepted transactions
  sample_t              hist_ring   [MAX_WIN];
  sample_t              sorted_vals [MAX_WIN];
  int                   held_count;
  int                   oldest_slot;
  logic [CFG_WIDTH-1:0] win_cfg;

  median_t     expected_medians [$];
  sample_txn_t pending_samples  [$];

  int  err_count     = 0;
  int  sent_count    = 0;
  int  checked_count = 0;
  int  cfg_count     = 0;
  int  cycle_count   = 0;
  int  in_gap        = 0;
  int  out_gap       = 0;
  bit  calm_in       = 1'b0;
  bit  calm_out      = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int window_len();
    if (win_cfg == 0) return 1;
    if (win_cfg > MAX_WIN) return MAX_WIN;
    return int'(win_cfg);
  endfunction

  function automatic void drop_sorted(sample_t value);
    int j;
    j = 0;
    while (j < held_count && sorted_vals[j] != value) j++;
    if (j >= held_count) return;
    while (j + 1 < held_count) begin
      sorted_vals[j] = sorted_vals[j+1];
      j++;
    end
    held_count--;
  endfunction

  function automatic void add_sorted(sample_t value);
    int i;
    i = held_count;
    if (i >= MAX_WIN) return;
    while (i > 0 && sorted_vals[i-1] > value) begin
      sorted_vals[i] = sorted_vals[i-1];
      i--;
    end
    sorted_vals[i] = value;
    held_count++;
  endfunction

  function automatic bit predict_median(sample_txn_t txn, output median_t median);
    int w;
    int slot;
    w = window_len();
    median = '0;
    if (txn.restart) begin
      held_count = 0;
      oldest_slot = 0;
    end
    if (held_count >= w) begin
      slot = (oldest_slot >= w) ? 0 : oldest_slot;
      drop_sorted(hist_ring[slot]);
      hist_ring[slot] = txn.sample;
      oldest_slot = (slot + 1 >= w) ? 0 : slot + 1;
    end else begin
      slot = oldest_slot + held_count;
      if (slot >= w) slot -= w;
      if (slot >= MAX_WIN) slot = 0;
      hist_ring[slot] = txn.sample;
    end
    add_sorted(txn.sample);
    if (held_count != w) return 1'b0;
    median = median_t'($signed(sorted_vals[(w-1)/2])) + median_t'($signed(sorted_vals[w/2]));
    return 1'b1;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t random_sample();
    int      r;
    sample_t v;
    r = $urandom_range(0, 99);
    if (r < 40) return sample_t'($urandom);
    if (r < 75) return sample_t'(int'($urandom_range(0, 16)) - 8);
    if (r < 90) begin
      case ($urandom_range(0, 5))
        0:       return S_MIN;
        1:       return S_MAX;
        2:       return sample_t'(0);
        3:       return sample_t'(-1);
        4:       return S_MIN + 1;
        default: return S_MAX - 1;
      endcase
    end
    v = sample_t'(1) << $urandom_range(0, SBITS - 1);
    if ($urandom_range(0, 1)) v = ~v;
    return v;
  endfunction

  // mirror of every accepted window write and sample transaction
  always @(posedge clk_i) begin
    sample_txn_t txn;
    median_t     med;
    if (rst_ni) begin
      if (cfg_we_i) begin
        win_cfg = cfg_data_i;
        held_count = 0;
        oldest_slot = 0;
      end
      if (in_valid_i && !in_stall_o) begin
        txn.sample = sample_i;
        txn.restart = restart_i;
        sent_count++;
        if (predict_median(txn, med)) expected_medians = {expected_medians, med};
      end
    end
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    sample_txn_t txn;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        txn = pending_samples.pop_front();
        sample_i <= txn.sample;
        restart_i <= txn.restart;
        in_valid_i <= 1'b1;
        in_gap = calm_in ? 0 : idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(posedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      out_gap = calm_out ? 0 : idle_len();
    end
  end

  // monitor
  always @(posedge clk_i) begin
    median_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_medians.size() == 0) begin
        err_count++;
        $error("median_doubled: no transaction expected, actual %0d", median_doubled_o);
      end else begin
        want = expected_medians.pop_front();
        checked_count++;
        if (median_doubled_o !== want) begin
          err_count++;
          $error("median_doubled mismatch: expected %0d, actual %0d", want, median_doubled_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_sample(sample_t s, logic r);
    sample_txn_t txn;
    txn.sample = s;
    txn.restart = r;
    pending_samples = {pending_samples, txn};
  endtask

  // block idle: nothing queued, nothing on the input, no result outstanding
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_medians.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(int value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= CFG_WIDTH'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_count++;
  endtask

  initial begin
    int v;
    int w;
    int len;
    int phase;
    int n_random;
    held_count = 0;
    oldest_slot = 0;
    win_cfg = CFG_WIDTH'(WINDOW_RESET);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset window of 3: extremes, restart mid-stream, equal values
    queue_sample(S_MIN, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample(0, 1'b0);
    queue_sample(-1, 1'b0);
    queue_sample(1, 1'b0);
    queue_sample(S_MAX, 1'b1);
    queue_sample(5, 1'b0);
    queue_sample(5, 1'b0);

    // size zero acts as one; restart still yields a result
    write_window(0);
    queue_sample(S_MIN, 1'b0);
    queue_sample(S_MAX, 1'b1);
    queue_sample(-1, 1'b0);

    // even window: sums beyond the sample range
    write_window(2);
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MIN, 1'b0);
    queue_sample(S_MIN, 1'b0);
    queue_sample(7, 1'b0);
    queue_sample(7, 1'b0);

    n_random = 0;
    phase = 0;
    while (n_random < RANDOM_ITEMS) begin
      case (phase)
        0: v = 127;
        1: v = 64;
        2: v = 1;
        3: v = 65;
        4: v = 0;
        5: v = 2;
        6: v = 33;
        default: begin
          len = $urandom_range(0, 99);
          if (len < 70) v = $urandom_range(1, 12);
          else if (len < 90) v = $urandom_range(13, 63);
          else v = $urandom_range(64, 127);
        end
      endcase
      write_window(v);
      w = (v == 0) ? 1 : ((v > MAX_WIN) ? MAX_WIN : v);
      calm_in = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      len = w + $urandom_range(8, 60);
      repeat (len) queue_sample(random_sample(), $urandom_range(0, 99) < 3);
      n_random += len;
      phase++;
    end

    wait_idle();
    $display("Run covered %0d sample transactions and %0d checked medians", sent_count,
             checked_count);
    $display("across %0d window-size writes plus the reset window", cfg_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
